// ===== hdl/u2u8_pkg.sv =====
// Package for the UTF-16 to UTF-8 transcoder: byte-burst types and the
// code point to UTF-8 encoding function. No dependencies.
package u2u8_pkg;

    localparam int MaxBytes = 6;

    // One encoded code point: up to four bytes, entry 0 goes out first.
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_seq;

    // All bytes caused by one input item.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [2:0]               count;
        logic                     last;
    } t_burst;

    localparam logic [20:0] CpReplace = 21'h00FFFD;
    localparam logic [20:0] CpSuppBase = 21'h010000;

    function automatic t_seq put_cp(input logic [20:0] cp);
        t_seq s;
        s.b = '0;
        if (cp < 21'h80) begin
            s.b[0] = {1'b0, cp[6:0]};
            s.len  = 3'd1;
        end else if (cp < 21'h800) begin
            s.b[0] = {3'b110, cp[10:6]};
            s.b[1] = {2'b10, cp[5:0]};
            s.len  = 3'd2;
        end else if (cp < 21'h10000) begin
            s.b[0] = {4'b1110, cp[15:12]};
            s.b[1] = {2'b10, cp[11:6]};
            s.b[2] = {2'b10, cp[5:0]};
            s.len  = 3'd3;
        end else begin
            s.b[0] = {5'b11110, cp[20:18]};
            s.b[1] = {2'b10, cp[17:12]};
            s.b[2] = {2'b10, cp[11:6]};
            s.b[3] = {2'b10, cp[5:0]};
            s.len  = 3'd4;
        end
        return s;
    endfunction

endpackage

// ===== hdl/utf16_to_utf8_transcoder_top.sv =====
// UTF-16 to UTF-8 transcoder, top level. Uses u2u8_pkg, u2u8_encoder and
// u2u8_serializer.
//
// Each input item is one UTF-16 code unit plus a last-of-stream flag; the
// block emits the matching UTF-8 bytes as output items, one byte per cycle
// while i_out_ready is high, with o_run_last on the final byte of each
// input item and o_stream_last on the final byte of the stream. A high
// surrogate is held and emits nothing until the next unit; paired with a
// low surrogate it becomes a 4-byte sequence, otherwise it turns into
// U+FFFD (EF BF BD) ahead of the new unit's own bytes. A high surrogate
// left at end of stream is flushed as U+FFFD, and a lone low surrogate is
// encoded as 3 bytes of its own value. An input item is encoded as it is
// taken and then sent out byte by byte; it has 0 to 6 bytes, and the
// single byte port sets the sustained rate. A pending-burst register lets
// the next item be taken while the current one is still draining, so items
// that encode to one byte flow at one per cycle while i_out_ready is high.
// No configuration, and the block is ready right after reset.
module utf16_to_utf8_transcoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_stream_last
);

    u2u8_pkg::t_burst burst;
    logic             fire;
    logic             room;

    // item accepted whenever the pending slot is free
    assign o_in_ready = room;
    assign fire       = i_in_valid && room;

    u2u8_encoder u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .o_burst     (burst)
    );

    // zero-byte items (held high surrogate) only update the held state
    u2u8_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (fire && (burst.count != 3'd0)),
        .i_burst       (burst),
        .o_room        (room),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_byte        (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_last (o_stream_last)
    );

endmodule

// ===== hdl/u2u8_encoder.sv =====
// Surrogate tracking and per-item UTF-8 encoding into one byte burst.
// Depends on u2u8_pkg.
module u2u8_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [15:0]       i_code_unit,
    input  logic              i_last_unit,
    output u2u8_pkg::t_burst  o_burst
);

    logic [9:0] r_held_high, n_held_high;
    logic       r_held_valid, n_held_valid;

    logic              is_high, is_low, pair, prefix;
    logic [20:0]       cp;
    u2u8_pkg::t_seq    seq, rep;

    assign is_high = (i_code_unit[15:10] == 6'b110110);
    assign is_low  = (i_code_unit[15:10] == 6'b110111);
    assign pair    = r_held_valid && is_low;
    // held high surrogate not completed by this unit
    assign prefix  = r_held_valid && !is_low;

    always_comb begin
        if (pair) begin
            cp = {1'b0, r_held_high, i_code_unit[9:0]} + u2u8_pkg::CpSuppBase;
        end else if (is_high) begin
            cp = u2u8_pkg::CpReplace;
        end else begin
            cp = {5'd0, i_code_unit};
        end
        seq = u2u8_pkg::put_cp(cp);
        rep = u2u8_pkg::put_cp(u2u8_pkg::CpReplace);
    end

    always_comb begin
        logic [2:0] nb;
        // a high surrogate that is not last emits nothing of its own
        nb = (is_high && !pair && !i_last_unit) ? 3'd0 : seq.len;
        o_burst.last = i_last_unit;
        if (prefix) begin
            o_burst.bytes = {seq.b[2:0], rep.b[2:0]};
            o_burst.count = nb + 3'd3;
        end else begin
            o_burst.bytes = {16'h0000, seq.b};
            o_burst.count = nb;
        end
    end

    always_comb begin
        n_held_high  = r_held_high;
        n_held_valid = r_held_valid;
        if (i_fire) begin
            if (is_high && !i_last_unit) begin
                n_held_high  = i_code_unit[9:0];
                n_held_valid = 1'b1;
            end else begin
                n_held_high  = '0;
                n_held_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_high  <= '0;
            r_held_valid <= 1'b0;
        end else begin
            r_held_high  <= n_held_high;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

// ===== hdl/u2u8_serializer.sv =====
// Two-entry burst buffer (active + pending) that sends one byte per cycle
// while i_ready is high. Depends on u2u8_pkg.
module u2u8_serializer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u2u8_pkg::t_burst  i_burst,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_run_last,
    output logic              o_stream_last
);

    u2u8_pkg::t_burst r_act, n_act, r_pnd, n_pnd;
    logic             r_act_valid, n_act_valid, r_pnd_valid, n_pnd_valid;
    logic [2:0]       r_idx, n_idx;
    logic             at_end, act_free;

    assign at_end   = (r_idx == r_act.count - 3'd1);
    assign act_free = !r_act_valid || (i_ready && at_end);

    assign o_room        = !r_pnd_valid;
    assign o_valid       = r_act_valid;
    assign o_byte        = r_act.bytes[r_idx];
    assign o_run_last    = at_end;
    assign o_stream_last = at_end && r_act.last;

    always_comb begin
        n_act       = r_act;
        n_pnd       = r_pnd;
        n_act_valid = r_act_valid;
        n_pnd_valid = r_pnd_valid;
        n_idx       = r_idx;
        if (act_free) begin
            n_idx = '0;
            if (r_pnd_valid) begin
                n_act       = r_pnd;
                n_act_valid = 1'b1;
                n_pnd_valid = 1'b0;
            end else begin
                n_act       = i_burst;
                n_act_valid = i_push;
            end
        end else begin
            if (i_ready) begin
                n_idx = r_idx + 3'd1;
            end
            if (i_push) begin
                n_pnd       = i_burst;
                n_pnd_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_pnd_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_act_valid <= n_act_valid;
            r_pnd_valid <= n_pnd_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
        r_pnd <= n_pnd;
    end

endmodule
